/* design/stack_machine_execute_top_assert.svh */
// ---------------------------------------------------------------------------
// stack machine execute assertion macros
// implication checks on the rising clock edge, disabled during reset
// ---------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH

`ifndef SYNTH
`define SME_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("stack machine assertion failed");
`define SME_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("stack machine assertion failed");
`else
`define SME_ASSERT_SAME(label, ante, cons)
`define SME_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* design/sme_pkg.sv */
// ---------------------------------------------------------------------------
// sme_pkg
// shared constants, opcodes, status codes and state type of the stack machine
// ---------------------------------------------------------------------------
package sme_pkg;

    localparam int MEM_DEPTH  = 4096;
    localparam int MEM_AW     = $clog2(MEM_DEPTH);
    localparam int PROG_DEPTH = 256;
    localparam int PROG_AW    = $clog2(PROG_DEPTH);
    localparam int WORD_W     = 32;
    localparam int DIV_CNT_W  = $clog2(WORD_W);

    localparam logic [7:0] OP_PUSH   = 8'd0;
    localparam logic [7:0] OP_IPUSH  = 8'd1;
    localparam logic [7:0] OP_PUSH2  = 8'd2;
    localparam logic [7:0] OP_POP    = 8'd3;
    localparam logic [7:0] OP_IPOP   = 8'd4;
    localparam logic [7:0] OP_DUP    = 8'd5;
    localparam logic [7:0] OP_ALU    = 8'd6;
    localparam logic [7:0] OP_JMP    = 8'd7;
    localparam logic [7:0] OP_JZ     = 8'd8;
    localparam logic [7:0] OP_RND    = 8'd11;
    localparam logic [7:0] OP_WRITE  = 8'd12;
    localparam logic [7:0] OP_READ   = 8'd13;
    localparam logic [7:0] OP_HALT   = 8'd99;

    localparam logic [3:0] ALU_AND = 4'd0;
    localparam logic [3:0] ALU_OR  = 4'd1;
    localparam logic [3:0] ALU_XOR = 4'd2;
    localparam logic [3:0] ALU_NOT = 4'd3;
    localparam logic [3:0] ALU_NEG = 4'd4;
    localparam logic [3:0] ALU_ADD = 4'd5;
    localparam logic [3:0] ALU_SUB = 4'd6;
    localparam logic [3:0] ALU_MUL = 4'd7;
    localparam logic [3:0] ALU_DIV = 4'd8;
    localparam logic [3:0] ALU_MOD = 4'd9;
    localparam logic [3:0] ALU_EQ  = 4'd10;
    localparam logic [3:0] ALU_NE  = 4'd11;
    localparam logic [3:0] ALU_GT  = 4'd12;
    localparam logic [3:0] ALU_GE  = 4'd13;
    localparam logic [3:0] ALU_LT  = 4'd14;
    localparam logic [3:0] ALU_LE  = 4'd15;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_HALT    = 2'd1;
    localparam logic [1:0] ST_ILLEGAL = 2'd2;
    localparam logic [1:0] ST_ZERO    = 2'd3;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_EXEC,
        S_DIV,
        S_FIN
    } t_state;

endpackage

/* design/sme_ram.sv */
// ---------------------------------------------------------------------------
// sme_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/stack_machine_execute_top.sv */
// ---------------------------------------------------------------------------
// stack_machine_execute_top
// executes one stack machine instruction per request against a word memory
// ---------------------------------------------------------------------------
// After reset the block clears its 4096-word memory, one word a cycle, and
// takes no request until the clear is done. Each instruction then goes
// through two reads, one after the other, of the single-port-read memory, an
// execute step and a write-back; a new request is taken only in idle. div,
// mod and rnd also pass through the bit-serial divider. A finished result sits
// in an output register, so the next request is taken while it waits.
module stack_machine_execute_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    output logic                              o_req_ready,
    input  logic [7:0]                        i_mode,
    input  logic signed [sme_pkg::WORD_W-1:0] i_argument,
    input  logic signed [sme_pkg::WORD_W-1:0] i_in_value,
    input  logic [sme_pkg::WORD_W-2:0]        i_random_value,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output logic [7:0]                        o_next_pc,
    output logic                              o_out_valid,
    output logic signed [sme_pkg::WORD_W-1:0] o_out_value,
    output logic [1:0]                        o_status
);

    import sme_pkg::*;

    t_state r_state, n_state;

    logic [MEM_AW-1:0]  r_clr;
    logic [PROG_AW-1:0] r_pc;
    logic [MEM_AW-1:0]  r_sp;
    logic               r_halted;

    logic [7:0]        r_mode;
    logic [WORD_W-1:0] r_arg;
    logic [WORD_W-1:0] r_inval;
    logic [WORD_W-2:0] r_rv;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;

    logic               r_p_wen, n_p_wen;
    logic [MEM_AW-1:0]  r_p_waddr, n_p_waddr;
    logic [WORD_W-1:0]  r_p_wdata, n_p_wdata;
    logic [MEM_AW-1:0]  r_p_sp, n_p_sp;
    logic [PROG_AW-1:0] r_p_pc, n_p_pc;
    logic [1:0]         r_p_status, n_p_status;
    logic               r_p_ovld, n_p_ovld;
    logic [WORD_W-1:0]  r_p_oval, n_p_oval;
    logic               r_p_halt, n_p_halt;
    logic               n_div_start;
    logic [WORD_W-1:0]  n_div_dvd, n_div_dvs;
    logic               n_div_qneg, n_div_rneg, n_div_selq;

    logic [WORD_W-1:0]    r_quo, r_rem, r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_qneg, r_rneg, r_selq;
    logic [WORD_W:0]      div_sh, div_diff;
    logic                 div_ge;
    logic [WORD_W-1:0]    div_rem_nx, div_quo_nx, div_q_fin, div_r_fin;

    logic                 r_res_valid;
    logic [PROG_AW-1:0]   r_o_pc;
    logic                 r_o_ovld;
    logic [WORD_W-1:0]    r_o_oval;
    logic [1:0]           r_o_status;

    logic              accept, fin_go;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata, mem_rdata;
    logic [MEM_AW-1:0] sp_m1, sp_m2, sp_p1, arg_addr;
    logic [PROG_AW-1:0] pc_p1, pc_jmp;
    logic [WORD_W-1:0] mul_res;
    logic [3:0]        sel;

    assign accept = i_req_valid && o_req_ready;
    assign fin_go = !r_res_valid || i_res_ready;

    assign sp_m1    = r_sp - MEM_AW'(1);
    assign sp_m2    = r_sp - MEM_AW'(2);
    assign sp_p1    = r_sp + MEM_AW'(1);
    assign arg_addr = r_arg[MEM_AW-1:0];
    assign pc_p1    = r_pc + PROG_AW'(1);
    assign pc_jmp   = r_pc + r_arg[PROG_AW-1:0];
    assign mul_res  = r_a * r_b;
    assign sel      = r_arg[3:0];

    sme_ram #(
        .WIDTH(WORD_W),
        .DEPTH(MEM_DEPTH)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        o_req_ready = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_p_waddr;
        mem_wdata   = r_p_wdata;
        mem_raddr   = (r_mode == OP_WRITE) ? arg_addr : sp_m1;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    n_state = S_RD1;
                end
            end
            S_RD1: begin
                n_state = S_RD2;
            end
            S_RD2: begin
                mem_raddr = (r_mode == OP_IPUSH) ? mem_rdata[MEM_AW-1:0] : sp_m2;
                n_state   = S_RD3;
            end
            S_RD3: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = n_div_start ? S_DIV : S_FIN;
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (fin_go) begin
                    mem_we  = r_p_wen;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_p_wen     = 1'b0;
        n_p_waddr   = r_sp;
        n_p_wdata   = '0;
        n_p_sp      = r_sp;
        n_p_pc      = pc_p1;
        n_p_status  = ST_OK;
        n_p_ovld    = 1'b0;
        n_p_oval    = '0;
        n_p_halt    = r_halted;
        n_div_start = 1'b0;
        n_div_dvd   = r_a[WORD_W-1] ? (WORD_W'(0) - r_a) : r_a;
        n_div_dvs   = r_b[WORD_W-1] ? (WORD_W'(0) - r_b) : r_b;
        n_div_qneg  = r_a[WORD_W-1] ^ r_b[WORD_W-1];
        n_div_rneg  = r_a[WORD_W-1];
        n_div_selq  = (sel == ALU_DIV);
        if (r_halted) begin
            n_p_status = ST_HALT;
            n_p_pc     = r_pc;
        end else begin
            unique case (r_mode)
                OP_PUSH, OP_PUSH2: begin
                    n_p_wen   = 1'b1;
                    n_p_wdata = r_arg;
                    n_p_sp    = sp_p1;
                end
                OP_IPUSH: begin
                    n_p_wen   = 1'b1;
                    n_p_waddr = sp_m1;
                    n_p_wdata = r_a;
                end
                OP_POP: begin
                    n_p_wen   = 1'b1;
                    n_p_waddr = arg_addr;
                    n_p_wdata = r_b;
                    n_p_sp    = sp_m1;
                end
                OP_IPOP: begin
                    n_p_wen   = 1'b1;
                    n_p_waddr = r_b[MEM_AW-1:0];
                    n_p_wdata = r_a;
                    n_p_sp    = sp_m2;
                end
                OP_DUP: begin
                    n_p_wen   = 1'b1;
                    n_p_wdata = r_b;
                    n_p_sp    = sp_p1;
                end
                OP_ALU: begin
                    if (r_arg[WORD_W-1:4] == '0) begin
                        if (sel == ALU_NOT || sel == ALU_NEG) begin
                            n_p_wen   = 1'b1;
                            n_p_waddr = sp_m1;
                            n_p_wdata = (sel == ALU_NOT) ? ~r_b : (WORD_W'(0) - r_b);
                        end else if ((sel == ALU_DIV || sel == ALU_MOD) && r_b == '0) begin
                            n_p_status = ST_ZERO;
                            n_p_pc     = r_pc;
                        end else begin
                            n_p_wen   = 1'b1;
                            n_p_waddr = sp_m2;
                            n_p_sp    = sp_m1;
                            unique case (sel)
                                ALU_AND: n_p_wdata = r_a & r_b;
                                ALU_OR:  n_p_wdata = r_a | r_b;
                                ALU_XOR: n_p_wdata = r_a ^ r_b;
                                ALU_ADD: n_p_wdata = r_a + r_b;
                                ALU_SUB: n_p_wdata = r_a - r_b;
                                ALU_MUL: n_p_wdata = mul_res;
                                ALU_EQ:  n_p_wdata = {31'd0, !($signed(r_a) == $signed(r_b))};
                                ALU_NE:  n_p_wdata = {31'd0, !($signed(r_a) != $signed(r_b))};
                                ALU_GT:  n_p_wdata = {31'd0, !($signed(r_a) >  $signed(r_b))};
                                ALU_GE:  n_p_wdata = {31'd0, !($signed(r_a) >= $signed(r_b))};
                                ALU_LT:  n_p_wdata = {31'd0, !($signed(r_a) <  $signed(r_b))};
                                ALU_LE:  n_p_wdata = {31'd0, !($signed(r_a) <= $signed(r_b))};
                                default: n_div_start = 1'b1;
                            endcase
                        end
                    end
                end
                OP_JMP: begin
                    n_p_pc = pc_jmp;
                end
                OP_JZ: begin
                    n_p_sp = sp_m1;
                    if (r_b == '0) begin
                        n_p_pc = pc_jmp;
                    end
                end
                OP_RND: begin
                    if (r_arg == '0) begin
                        n_p_status = ST_ZERO;
                        n_p_pc     = r_pc;
                    end else begin
                        n_p_wen     = 1'b1;
                        n_p_sp      = sp_p1;
                        n_div_start = 1'b1;
                        n_div_dvd   = {1'b0, r_rv};
                        n_div_dvs   = r_arg[WORD_W-1] ? (WORD_W'(0) - r_arg) : r_arg;
                        n_div_qneg  = 1'b0;
                        n_div_rneg  = 1'b0;
                        n_div_selq  = 1'b0;
                    end
                end
                OP_WRITE: begin
                    n_p_ovld = 1'b1;
                    n_p_oval = r_b;
                end
                OP_READ: begin
                    n_p_wen   = 1'b1;
                    n_p_waddr = arg_addr;
                    n_p_wdata = r_inval;
                end
                OP_HALT: begin
                    n_p_status = ST_HALT;
                    n_p_pc     = r_pc;
                    n_p_halt   = 1'b1;
                end
                default: begin
                    n_p_status = ST_ILLEGAL;
                    n_p_pc     = r_pc;
                end
            endcase
        end
    end

    // restoring divider step on magnitudes
    always_comb begin
        div_sh     = {r_rem, r_quo[WORD_W-1]};
        div_diff   = div_sh - {1'b0, r_dvs};
        div_ge     = !div_diff[WORD_W];
        div_rem_nx = div_ge ? div_diff[WORD_W-1:0] : div_sh[WORD_W-1:0];
        div_quo_nx = {r_quo[WORD_W-2:0], div_ge};
        div_q_fin  = r_qneg ? (WORD_W'(0) - div_quo_nx) : div_quo_nx;
        div_r_fin  = r_rneg ? (WORD_W'(0) - div_rem_nx) : div_rem_nx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pc        <= '0;
            r_sp        <= '0;
            r_halted    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + MEM_AW'(1);
            end
            if (r_state == S_FIN && fin_go) begin
                r_pc        <= r_p_pc;
                r_sp        <= r_p_sp;
                r_halted    <= r_p_halt;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_arg   <= i_argument;
            r_inval <= i_in_value;
            r_rv    <= i_random_value;
        end
        if (r_state == S_RD2) begin
            r_b <= mem_rdata;
        end
        if (r_state == S_RD3) begin
            r_a <= mem_rdata;
        end
        if (r_state == S_EXEC) begin
            r_p_wen    <= n_p_wen;
            r_p_waddr  <= n_p_waddr;
            r_p_wdata  <= n_p_wdata;
            r_p_sp     <= n_p_sp;
            r_p_pc     <= n_p_pc;
            r_p_status <= n_p_status;
            r_p_ovld   <= n_p_ovld;
            r_p_oval   <= n_p_oval;
            r_p_halt   <= n_p_halt;
            r_quo      <= n_div_dvd;
            r_rem      <= '0;
            r_dvs      <= n_div_dvs;
            r_qneg     <= n_div_qneg;
            r_rneg     <= n_div_rneg;
            r_selq     <= n_div_selq;
            r_cnt      <= DIV_CNT_W'(WORD_W - 1);
        end
        if (r_state == S_DIV) begin
            r_quo <= div_quo_nx;
            r_rem <= div_rem_nx;
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                r_p_wdata <= r_selq ? div_q_fin : div_r_fin;
            end
        end
        if (r_state == S_FIN && fin_go) begin
            r_o_pc     <= r_p_pc;
            r_o_ovld   <= r_p_ovld;
            r_o_oval   <= r_p_oval;
            r_o_status <= r_p_status;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_next_pc   = r_o_pc;
    assign o_out_valid = r_o_ovld;
    assign o_out_value = r_o_oval;
    assign o_status    = r_o_status;

    `include "stack_machine_execute_top_assert.svh"

    `SME_ASSERT_NEXT(a_accept_reads, accept, r_state == S_RD1)
    `SME_ASSERT_NEXT(a_div_exit, r_state == S_DIV, r_state == S_DIV || r_state == S_FIN)
    `SME_ASSERT_SAME(a_err_no_write, r_state == S_FIN && r_p_status != ST_OK, !r_p_wen)
    `SME_ASSERT_SAME(a_halt_status, r_state == S_FIN && r_halted, r_p_status == ST_HALT)

endmodule
